>>> rtl/core/ltu_pkg.sv
// ltu_pkg: shared types, constants and encode helpers for the legacy text to utf-8 converter
// no dependencies; imported by ltu_front, ltu_back and the top level
`default_nettype none

package ltu_pkg;

  localparam int unsigned LtuQueueDepth = 2;

  typedef enum logic [1:0] {
    ModeUtf8   = 2'd0,
    ModeLatin1 = 2'd1,
    ModeUtf16  = 2'd2,
    ModeLatin2 = 2'd3
  } ltu_mode_e;

  // one code point handed from front to back; raw words go out unchanged
  typedef struct packed {
    logic        raw;
    logic [15:0] cp;
  } ltu_unit_t;

  localparam int unsigned UnitWidth = $bits(ltu_unit_t);

  localparam logic [7:0] Latin2Base = 8'hA0;

  localparam logic [9:0] Latin2Upper [96] = '{
    10'h0A0, 10'h104, 10'h2D8, 10'h141, 10'h0A4, 10'h13D, 10'h15A, 10'h0A7,
    10'h0A8, 10'h160, 10'h15E, 10'h164, 10'h179, 10'h0AD, 10'h17D, 10'h17B,
    10'h0B0, 10'h105, 10'h2DB, 10'h142, 10'h0B4, 10'h13E, 10'h15B, 10'h2C7,
    10'h0B8, 10'h161, 10'h15F, 10'h165, 10'h17A, 10'h2DD, 10'h17E, 10'h17C,
    10'h154, 10'h0C1, 10'h0C2, 10'h102, 10'h0C4, 10'h139, 10'h106, 10'h0C7,
    10'h10C, 10'h0C9, 10'h118, 10'h0CB, 10'h11A, 10'h0CD, 10'h0CE, 10'h10E,
    10'h110, 10'h143, 10'h147, 10'h0D3, 10'h0D4, 10'h150, 10'h0D6, 10'h0D7,
    10'h158, 10'h16E, 10'h0DA, 10'h170, 10'h0DC, 10'h0DD, 10'h162, 10'h0DF,
    10'h155, 10'h0E1, 10'h0E2, 10'h103, 10'h0E4, 10'h13A, 10'h107, 10'h0E7,
    10'h10D, 10'h0E9, 10'h119, 10'h0EB, 10'h11B, 10'h0ED, 10'h0EE, 10'h10F,
    10'h111, 10'h144, 10'h148, 10'h0F3, 10'h0F4, 10'h151, 10'h0F6, 10'h0F7,
    10'h159, 10'h16F, 10'h0FA, 10'h171, 10'h0FC, 10'h0FD, 10'h163, 10'h2D9
  };

  function automatic logic [15:0] ltu_latin2(logic [7:0] b);
    logic [6:0] idx;
    idx = 7'(b - Latin2Base);
    if (b >= Latin2Base) begin
      return {6'd0, Latin2Upper[idx]};
    end
    return {8'd0, b};
  endfunction

  // number of utf-8 bytes for one unit, 1 to 3
  function automatic logic [1:0] ltu_len(ltu_unit_t u);
    if (u.raw || u.cp[15:7] == '0) begin
      return 2'd1;
    end
    if (u.cp[15:11] == '0) begin
      return 2'd2;
    end
    return 2'd3;
  endfunction

  function automatic logic [7:0] ltu_byte(ltu_unit_t u, logic [1:0] idx);
    logic [1:0] len;
    len = ltu_len(u);
    if (u.raw) begin
      return u.cp[7:0];
    end
    if (len == 2'd1) begin
      return {1'b0, u.cp[6:0]};
    end
    if (len == 2'd2) begin
      return (idx == 2'd0) ? {3'b110, u.cp[10:6]} : {2'b10, u.cp[5:0]};
    end
    if (idx == 2'd0) begin
      return {4'b1110, u.cp[15:12]};
    end
    if (idx == 2'd1) begin
      return {2'b10, u.cp[11:6]};
    end
    return {2'b10, u.cp[5:0]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ltu_fifo.sv
// ltu_fifo: short register queue between the decode front and the encode back
// standalone, no package use
`default_nettype none

module ltu_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastAddr) ? '0 : wptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastAddr) ? '0 : rptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ltu_front.sv
// ltu_front: mode register, input word accept, utf-16 pairing and latin-2 lookup
// depends on ltu_pkg; feeds code points into ltu_fifo
`default_nettype none

module ltu_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_data_i,
  input  wire logic               push_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               end_of_text_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output ltu_pkg::ltu_unit_t      q_unit_o
);
  import ltu_pkg::*;

  ltu_mode_e  mode_q, mode_d;
  logic [7:0] held_q, held_d;
  logic       held_valid_q, held_valid_d;
  logic       accept;

  assign accept = push_i && !q_full_i;

  always_comb begin
    mode_d       = mode_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    q_push_o     = 1'b0;
    q_unit_o     = '{raw: 1'b0, cp: {8'd0, in_byte_i}};
    if (cfg_we_i) begin
      mode_d       = ltu_mode_e'(cfg_data_i);
      held_valid_d = 1'b0;
    end else if (accept) begin
      held_valid_d = 1'b0;
      unique case (mode_q)
        ModeUtf8: begin
          q_push_o     = 1'b1;
          q_unit_o.raw = 1'b1;
        end
        ModeLatin1: begin
          q_push_o = 1'b1;
        end
        ModeLatin2: begin
          q_push_o    = 1'b1;
          q_unit_o.cp = ltu_latin2(in_byte_i);
        end
        ModeUtf16: begin
          if (held_valid_q) begin
            q_push_o    = 1'b1;
            q_unit_o.cp = {held_q, in_byte_i};
          end else if (!end_of_text_i) begin
            held_d       = in_byte_i;
            held_valid_d = 1'b1;
          end
        end
        default: begin
          q_push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeUtf8;
      held_valid_q <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      held_valid_q <= held_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/ltu_back.sv
// ltu_back: utf-8 serializer, one output word per cycle into the output register
// when free or popped; depends on ltu_pkg; drains code points from ltu_fifo
`default_nettype none

module ltu_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ltu_pkg::ltu_unit_t q_unit_i,
  input  wire logic               q_empty_i,
  output logic                    q_pop_o,
  input  wire logic               pop,
  output logic                    empty,
  output logic [7:0]              out_byte_o,
  output logic                    run_last_o
);
  import ltu_pkg::*;

  ltu_unit_t  cur_q, cur_d, src;
  logic [1:0] idx_q, idx_d, src_idx, src_len;
  logic       busy_q, busy_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       have, advance, last;

  assign src     = busy_q ? cur_q : q_unit_i;
  assign src_idx = busy_q ? idx_q : 2'd0;
  assign src_len = ltu_len(src);
  assign last    = (src_idx == src_len - 2'd1);
  assign have    = busy_q || !q_empty_i;
  assign advance = have && (!out_valid_q || pop);
  assign q_pop_o = advance && !busy_q;

  assign empty      = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign run_last_o = out_last_q;

  always_comb begin
    cur_d       = cur_q;
    idx_d       = idx_q;
    busy_d      = busy_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_byte_d  = ltu_byte(src, src_idx);
      out_last_d  = last;
      busy_d      = !last;
      cur_d       = src;
      idx_d       = src_idx + 2'd1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    idx_q      <= idx_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/legacy_text_to_utf8_converter.sv
// legacy_text_to_utf8_converter: top level, front decode, queue and utf-8 back end
// depends on ltu_pkg, ltu_front, ltu_fifo, ltu_back
//
// Byte-serial transcoder to UTF-8. cfg_data_i selects the source encoding
// (0 UTF-8 copy, 1 Latin-1, 2 UTF-16BE without surrogate pairing, 3 Latin-2)
// and the user must write it only while the block is idle; the block does not
// enforce this. A write drops any pending UTF-16 high byte. The front takes one
// input word per cycle while full is low and turns it into a code point; a short
// queue of QueueDepth entries sits between it and the back end, which writes one
// UTF-8 word per cycle into the output register while that register is empty or
// popped. An input word therefore yields 1 to 3 output words (its UTF-8 length)
// and a UTF-16 pair yields its length over two input words.
// run_last_o marks the final word produced by an input word.
`default_nettype none

module legacy_text_to_utf8_converter #(
  parameter int unsigned QueueDepth = ltu_pkg::LtuQueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_data_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_text_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o
);
  import ltu_pkg::*;

  ltu_unit_t front_unit, back_unit;
  logic      q_push, q_pop, q_empty;

  ltu_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_data_i,
    .push_i        (push),
    .in_byte_i,
    .end_of_text_i,
    .q_full_i      (full),
    .q_push_o      (q_push),
    .q_unit_o      (front_unit)
  );

  ltu_fifo #(
    .Width (UnitWidth),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .data_i  (front_unit),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (back_unit),
    .empty_o (q_empty)
  );

  ltu_back u_back (
    .clk_i,
    .rst_ni,
    .q_unit_i  (back_unit),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pop,
    .empty,
    .out_byte_o,
    .run_last_o
  );

endmodule

`default_nettype wire

>>> rtl/core/ltu_checker.sv
// ltu_checker: port-level assertions for legacy_text_to_utf8_converter
// bound to the top level below; no package use
`default_nettype none

module ltu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte_o,
  input wire logic       run_last_o
);

  // nothing waits and the queue has room while in reset
  a_reset_idle: assert property (@(posedge clk_i) (!rst_ni ##1 !rst_ni) |-> (empty && !full))
    else $error("output or queue not clear during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(run_last_o)))
    else $error("waiting word changed before pop");

  // a word that is not last belongs to a multi-word sequence
  a_multi_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !run_last_o) |-> out_byte_o[7])
    else $error("non-last word without high bit");

  // the rest of a sequence follows with no gap and as continuation words
  a_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !run_last_o) |=> (!empty && out_byte_o[7:6] == 2'b10))
    else $error("sequence not continued");

endmodule

bind legacy_text_to_utf8_converter ltu_checker u_ltu_checker (
  .clk_i,
  .rst_ni,
  .full,
  .empty,
  .pop,
  .out_byte_o,
  .run_last_o
);

`default_nettype wire

>>> dv/testbench.sv
// testbench: self-checking regression for legacy_text_to_utf8_converter
// depends on ltu_pkg and the converter rtl; predicts utf-8 words per source byte
// and checks them in order under random push and pop gaps across all decode modes
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ltu_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int PhaseItems = 45;
  localparam int NumPhases = 8;
  localparam int NumRows = 34;
  localparam int TypeFree = -1;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } utf8_word_t;

  typedef struct packed {
    logic       is_cfg;
    ltu_mode_e  mode;
    logic [7:0] b;
    logic       eot;
    int         n;
    logic [7:0] w0;
    logic [7:0] w1;
    logic [7:0] w2;
  } text_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_data_i = 2'd0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte_i = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_last_o;

  // iso-8859-2 code points for bytes 0xa0 to 0xff
  logic [15:0] iso8859_2_upper [96] = '{
    16'h0A0, 16'h104, 16'h2D8, 16'h141, 16'h0A4, 16'h13D, 16'h15A, 16'h0A7,
    16'h0A8, 16'h160, 16'h15E, 16'h164, 16'h179, 16'h0AD, 16'h17D, 16'h17B,
    16'h0B0, 16'h105, 16'h2DB, 16'h142, 16'h0B4, 16'h13E, 16'h15B, 16'h2C7,
    16'h0B8, 16'h161, 16'h15F, 16'h165, 16'h17A, 16'h2DD, 16'h17E, 16'h17C,
    16'h154, 16'h0C1, 16'h0C2, 16'h102, 16'h0C4, 16'h139, 16'h106, 16'h0C7,
    16'h10C, 16'h0C9, 16'h118, 16'h0CB, 16'h11A, 16'h0CD, 16'h0CE, 16'h10E,
    16'h110, 16'h143, 16'h147, 16'h0D3, 16'h0D4, 16'h150, 16'h0D6, 16'h0D7,
    16'h158, 16'h16E, 16'h0DA, 16'h170, 16'h0DC, 16'h0DD, 16'h162, 16'h0DF,
    16'h155, 16'h0E1, 16'h0E2, 16'h103, 16'h0E4, 16'h13A, 16'h107, 16'h0E7,
    16'h10D, 16'h0E9, 16'h119, 16'h0EB, 16'h11B, 16'h0ED, 16'h0EE, 16'h10F,
    16'h111, 16'h144, 16'h148, 16'h0F3, 16'h0F4, 16'h151, 16'h0F6, 16'h0F7,
    16'h159, 16'h16F, 16'h0FA, 16'h171, 16'h0FC, 16'h0FD, 16'h163, 16'h2D9
  };

  // directed text: mode writes and source bytes, typed words where obvious
  text_row_t text_rows [NumRows] = '{
    '{1'b0, ModeUtf8,   8'h00, 1'b0, 1,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeUtf8,   8'hFF, 1'b1, 1,        8'hFF, 8'h00, 8'h00},
    '{1'b1, ModeLatin1, 8'h00, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeLatin1, 8'h7F, 1'b0, 1,        8'h7F, 8'h00, 8'h00},
    '{1'b0, ModeLatin1, 8'h80, 1'b0, 2,        8'hC2, 8'h80, 8'h00},
    '{1'b0, ModeLatin1, 8'hFF, 1'b1, 2,        8'hC3, 8'hBF, 8'h00},
    '{1'b1, ModeLatin2, 8'h00, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeLatin2, 8'h9F, 1'b0, 2,        8'hC2, 8'h9F, 8'h00},
    '{1'b0, ModeLatin2, 8'hA1, 1'b0, 2,        8'hC4, 8'h84, 8'h00},
    '{1'b0, ModeLatin2, 8'hA2, 1'b0, 2,        8'hCB, 8'h98, 8'h00},
    '{1'b0, ModeLatin2, 8'hFF, 1'b1, 2,        8'hCB, 8'h99, 8'h00},
    '{1'b0, ModeLatin2, 8'hB7, 1'b0, TypeFree, 8'h00, 8'h00, 8'h00},
    '{1'b1, ModeUtf16,  8'h00, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeUtf16,  8'h00, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeUtf16,  8'h41, 1'b0, 1,        8'h41, 8'h00, 8'h00},
    '{1'b0, ModeUtf16,  8'h07, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeUtf16,  8'hFF, 1'b0, 2,        8'hDF, 8'hBF, 8'h00},
    '{1'b0, ModeUtf16,  8'h08, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeUtf16,  8'h00, 1'b0, 3,        8'hE0, 8'hA0, 8'h80},
    '{1'b0, ModeUtf16,  8'hD8, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeUtf16,  8'h00, 1'b0, 3,        8'hED, 8'hA0, 8'h80},
    '{1'b0, ModeUtf16,  8'hFF, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeUtf16,  8'hFF, 1'b0, 3,        8'hEF, 8'hBF, 8'hBF},
    '{1'b0, ModeUtf16,  8'h5A, 1'b1, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeUtf16,  8'h00, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeUtf16,  8'hE9, 1'b1, 2,        8'hC3, 8'hA9, 8'h00},
    '{1'b0, ModeUtf16,  8'hAB, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b1, ModeLatin1, 8'h00, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeLatin1, 8'h41, 1'b0, 1,        8'h41, 8'h00, 8'h00},
    '{1'b1, ModeUtf16,  8'h00, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeUtf16,  8'hC3, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b1, ModeUtf16,  8'h00, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeUtf16,  8'h00, 1'b0, 0,        8'h00, 8'h00, 8'h00},
    '{1'b0, ModeUtf16,  8'h41, 1'b0, 1,        8'h41, 8'h00, 8'h00}
  };

  ltu_mode_e  phase_order [4] = '{ModeUtf8, ModeLatin2, ModeLatin1, ModeUtf16};

  utf8_word_t utf8_q [$];
  ltu_mode_e  cur_mode = ModeUtf8;
  logic [7:0] hold_byte = 8'h00;
  logic       hold_valid = 1'b0;
  logic       tx_burst = 1'b0;
  logic       rx_burst = 1'b0;
  int         errors = 0;
  int         items_sent = 0;
  int         words_checked = 0;
  int         mode_writes = 0;
  int         mode_items [4] = '{0, 0, 0, 0};
  int         quiet = 0;

  legacy_text_to_utf8_converter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void add_word(logic [7:0] data, logic last);
    utf8_word_t w;
    w.data = data;
    w.last = last;
    utf8_q.push_back(w);
  endfunction

  function automatic void encode_code_point(logic [15:0] cp);
    if (cp < 16'h0080) begin
      add_word(cp[7:0], 1'b1);
    end else if (cp < 16'h0800) begin
      add_word({3'b110, cp[10:6]}, 1'b0);
      add_word({2'b10, cp[5:0]}, 1'b1);
    end else begin
      add_word({4'b1110, cp[15:12]}, 1'b0);
      add_word({2'b10, cp[11:6]}, 1'b0);
      add_word({2'b10, cp[5:0]}, 1'b1);
    end
  endfunction

  // expected utf-8 words for one accepted source byte
  function automatic void transcode_byte(logic [7:0] b, logic eot);
    case (cur_mode)
      ModeUtf8: begin
        hold_valid = 1'b0;
        add_word(b, 1'b1);
      end
      ModeLatin1: begin
        hold_valid = 1'b0;
        encode_code_point({8'h00, b});
      end
      ModeLatin2: begin
        hold_valid = 1'b0;
        encode_code_point((b >= 8'hA0) ? iso8859_2_upper[7'(b - 8'hA0)] : {8'h00, b});
      end
      default: begin
        if (!hold_valid) begin
          if (!eot) begin
            hold_byte = b;
            hold_valid = 1'b1;
          end
        end else begin
          hold_valid = 1'b0;
          encode_code_point({hold_byte, b});
        end
      end
    endcase
  endfunction

  function automatic int tx_gap();
    if ($urandom_range(0, 19) == 0) begin
      tx_burst = ~tx_burst;
    end
    return tx_burst ? 0 : int'($urandom_range(0, 17));
  endfunction

  function automatic int rx_gap();
    if ($urandom_range(0, 19) == 0) begin
      rx_burst = ~rx_burst;
    end
    return rx_burst ? 0 : int'($urandom_range(0, 17));
  endfunction

  function automatic logic [7:0] rand_text_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h00, 8'h7F));
      1: return 8'($urandom_range(8'h80, 8'h9F));
      2: return 8'($urandom_range(8'hA0, 8'hFF));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] rand_high_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'($urandom_range(8'h01, 8'h07));
      2: return 8'($urandom_range(8'h08, 8'hFF));
      default: return 8'($urandom_range(8'hD8, 8'hDF));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eot, input int n,
                           input logic [7:0] w0, input logic [7:0] w1,
                           input logic [7:0] w2);
    int gap;
    int mark;
    gap = tx_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    in_byte_i     <= b;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    mark = utf8_q.size();
    transcode_byte(b, eot);
    if (n >= 0) begin
      while (utf8_q.size() > mark) void'(utf8_q.pop_back());
      if (n > 0) add_word(w0, n == 1);
      if (n > 1) add_word(w1, n == 2);
      if (n > 2) add_word(w2, 1'b1);
    end
    items_sent++;
    mode_items[cur_mode]++;
  endtask

  task automatic send_text(input logic [7:0] b, input logic eot);
    send_byte(b, eot, TypeFree, 8'h00, 8'h00, 8'h00);
  endtask

  // mode writes only land once the block has drained
  task automatic write_mode(input ltu_mode_e m);
    push <= 1'b0;
    while (utf8_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_mode   = m;
    hold_valid = 1'b0;
    hold_byte  = 8'h00;
    mode_writes++;
  endtask

  initial begin
    ltu_mode_e ph_mode;
    int        sent;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (text_rows[i]) begin
      if (text_rows[i].is_cfg) begin
        write_mode(text_rows[i].mode);
      end else begin
        send_byte(text_rows[i].b, text_rows[i].eot, text_rows[i].n,
                  text_rows[i].w0, text_rows[i].w1, text_rows[i].w2);
      end
    end
    for (int ph = 0; ph < NumPhases; ph++) begin
      ph_mode = (ph < 4) ? phase_order[ph] : ltu_mode_e'($urandom_range(0, 3));
      write_mode(ph_mode);
      sent = 0;
      while (sent < PhaseItems) begin
        if (ph_mode == ModeUtf16) begin
          if ($urandom_range(0, 6) == 0) begin
            // lone byte closing a text
            send_text(rand_text_byte(), 1'b1);
            sent++;
          end else begin
            send_text(rand_high_byte(), 1'b0);
            send_text(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            sent += 2;
          end
        end else begin
          send_text(rand_text_byte(), $urandom_range(0, 7) == 0);
          sent++;
        end
      end
      // leave a high byte pending across the next mode write
      if (ph_mode == ModeUtf16 && $urandom_range(0, 1) == 0) begin
        send_text(rand_high_byte(), 1'b0);
      end
    end
    write_mode(ModeLatin2);
    push <= 1'b0;
    repeat (16) @(posedge clk_i);
    $display("covered %0d source bytes (utf-8 %0d, latin-1 %0d, utf-16be %0d, latin-2 %0d)",
             items_sent, mode_items[ModeUtf8], mode_items[ModeLatin1],
             mode_items[ModeUtf16], mode_items[ModeLatin2]);
    $display("checked %0d utf-8 words over %0d mode writes, %0d errors",
             words_checked, mode_writes, errors);
    if (errors == 0 && utf8_q.size() == 0) begin
      $display("legacy_text_to_utf8_converter regression: pass");
    end else begin
      $display("legacy_text_to_utf8_converter regression: fail");
    end
    $finish;
  end

  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = rx_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    utf8_word_t w;
    if (rst_ni && pop && !empty) begin
      words_checked++;
      if (utf8_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: actual byte %02h last %0b",
                 $time, out_byte_o, run_last_o);
      end else begin
        w = utf8_q.pop_front();
        if (out_byte_o !== w.data) begin
          errors++;
          $display("%0t: out_byte mismatch: expected %02h actual %02h",
                   $time, w.data, out_byte_o);
        end
        if (run_last_o !== w.last) begin
          errors++;
          $display("%0t: run_last mismatch: expected %0b actual %0b",
                   $time, w.last, run_last_o);
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("%0t: no progress for %0d cycles, %0d words outstanding",
                 $time, quiet, utf8_q.size());
        $display("legacy_text_to_utf8_converter regression: fail");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/ltu_pkg.sv
rtl/core/ltu_fifo.sv
rtl/core/ltu_front.sv
rtl/core/ltu_back.sv
rtl/core/legacy_text_to_utf8_converter.sv
rtl/core/ltu_checker.sv
dv/testbench.sv
